/* sv/ocst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ocst_pkg;

	// Table size and derived widths
	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int REM_W    = CNT_W + 1;

	// Field widths fixed by the interface
	localparam int CMD_W    = 3;
	localparam int SUIT_W   = 3;
	localparam int NUM_W    = 4;
	localparam int CODE_W   = SUIT_W + NUM_W;
	localparam int POS_W    = 8;
	localparam int WHERE_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int STEP_W   = $clog2(POS_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POS_W - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT      = 3'd0,
		CMD_REMOVE_CARD = 3'd1,
		CMD_REMOVE_NUM  = 3'd2,
		CMD_PICKUP      = 3'd3,
		CMD_LOCATE_CARD = 3'd4,
		CMD_LOCATE_NUM  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOD,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SUIT_W-1:0] card_suit;
		logic [NUM_W-1:0]  card_number;
		logic [POS_W-1:0]  position;
	} in_word_t;

	typedef struct packed {
		logic               ok;
		logic [WHERE_W-1:0] where;
		logic [SUIT_W-1:0]  out_suit;
		logic [NUM_W-1:0]   out_number;
		logic [COUNT_W-1:0] count;
	} out_word_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [CODE_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

/* sv/ocst_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module ocst_mem
	import ocst_pkg::*;
(
	input  wire logic              clk,
	input  mem_req_t               req,
	output logic      [CODE_W-1:0] rdata
);

	logic [CODE_W-1:0] mem [CAPACITY];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

/* sv/ocst_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ocst_seq
	import ocst_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  in_word_t               in_word,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_take,
	output out_word_t              res,
	output mem_req_t               mem_req,
	input  wire logic [CODE_W-1:0] rdata
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  held_q, held_d;
	logic              rvalid_s1, rvalid_d;
	logic [CMD_W-1:0]  cmd_q, cmd_d;
	logic [CODE_W-1:0] code_q, code_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  hit_q, hit_d;
	logic [CODE_W-1:0] card_q, card_d;
	logic              ok_q, ok_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [IDX_W-1:0]  raddr_s1, raddr_d;

	logic              by_num;
	logic              hit_now;
	logic              issue;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  rem_new;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			held_q    <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			held_q    <= held_d;
			rvalid_s1 <= rvalid_d;
		end
	end

	// Working registers of the current command
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		code_q   <= code_d;
		pos_q    <= pos_d;
		idx_q    <= idx_d;
		hit_q    <= hit_d;
		card_q   <= card_d;
		ok_q     <= ok_d;
		rem_q    <= rem_d;
		step_q   <= step_d;
		raddr_s1 <= raddr_d;
	end

	// Shared compare and compare-subtract
	assign by_num  = (cmd_q == CMD_REMOVE_NUM) || (cmd_q == CMD_LOCATE_NUM);
	assign hit_now = rvalid_s1 && (by_num ? (rdata[NUM_W-1:0] == code_q[NUM_W-1:0])
	                                      : (rdata == code_q));
	assign issue   = idx_q < held_q;
	assign rem_sh  = {rem_q[REM_W-2:0], pos_q[POS_W-1]};
	assign rem_new = (rem_sh >= REM_W'(held_q)) ? (rem_sh - REM_W'(held_q)) : rem_sh;

	// Sequencer
	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		rvalid_d = 1'b0;
		cmd_d   = cmd_q;
		code_d  = code_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		hit_d   = hit_q;
		card_d  = card_q;
		ok_d    = ok_q;
		rem_d   = rem_q;
		step_d  = step_q;
		raddr_d = raddr_s1;
		mem_req.we    = 1'b0;
		mem_req.waddr = hit_q;
		mem_req.wdata = code_q;
		mem_req.raddr = idx_q[IDX_W-1:0];
		idle      = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					cmd_d  = in_word.cmd;
					code_d = {in_word.card_suit, in_word.card_number};
					pos_d  = in_word.position;
					idx_d  = '0;
					hit_d  = '0;
					card_d = '0;
					ok_d   = 1'b0;
					rem_d  = '0;
					step_d = '0;
					case (in_word.cmd) inside
						CMD_INSERT, CMD_REMOVE_CARD, CMD_REMOVE_NUM,
						CMD_LOCATE_CARD, CMD_LOCATE_NUM: begin
							state_d = ST_SCAN;
						end
						CMD_PICKUP: begin
							state_d = (held_q == '0) ? ST_DONE : ST_MOD;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			ST_SCAN: begin
				if (hit_now) begin
					// First match: finish or move on to compaction
					hit_d = raddr_s1;
					ok_d  = 1'b1;
					case (cmd_q)
						CMD_INSERT: begin
							card_d  = code_q;
							state_d = ST_DONE;
						end
						CMD_REMOVE_CARD, CMD_REMOVE_NUM: begin
							card_d  = rdata;
							idx_d   = CNT_W'(raddr_s1);
							state_d = ST_SHIFT;
						end
						default: begin
							card_d  = rdata;
							state_d = ST_DONE;
						end
					endcase
				end else if (issue) begin
					// Advance the read pointer
					rvalid_d = 1'b1;
					raddr_d  = idx_q[IDX_W-1:0];
					idx_d    = idx_q + 1'b1;
				end else begin
					// No match anywhere: append on insert if there is room
					if ((cmd_q == CMD_INSERT) && (held_q < CNT_W'(CAPACITY))) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = held_q[IDX_W-1:0];
						hit_d  = held_q[IDX_W-1:0];
						card_d = code_q;
						ok_d   = 1'b1;
						held_d = held_q + 1'b1;
					end
					state_d = ST_DONE;
				end
			end

			ST_MOD: begin
				// One remainder bit per cycle
				rem_d  = rem_new;
				pos_d  = pos_q << 1;
				step_d = step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					idx_d   = CNT_W'(rem_new);
					hit_d   = IDX_W'(rem_new);
					ok_d    = 1'b1;
					state_d = ST_SHIFT;
				end
			end

			ST_SHIFT: begin
				// Take the picked card, then move each later entry down one place
				if (rvalid_s1) begin
					if (raddr_s1 == hit_q) begin
						card_d = rdata;
					end else begin
						mem_req.we    = 1'b1;
						mem_req.waddr = raddr_s1 - 1'b1;
						mem_req.wdata = rdata;
					end
				end
				if (issue) begin
					rvalid_d = 1'b1;
					raddr_d  = idx_q[IDX_W-1:0];
					idx_d    = idx_q + 1'b1;
				end else begin
					held_d  = held_q - 1'b1;
					state_d = ST_DONE;
				end
			end

			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result word; failures report zeros
	always_comb begin
		res.ok         = ok_q;
		res.where      = ok_q ? WHERE_W'(hit_q) : '0;
		res.out_suit   = ok_q ? card_q[CODE_W-1:NUM_W] : '0;
		res.out_number = ok_q ? card_q[NUM_W-1:0] : '0;
		res.count      = COUNT_W'(held_q);
	end

endmodule

`default_nettype wire

/* sv/ordered_card_set_table_top.sv */
// Lookup and insert walk the held cards up to the first match; removal adds
// compaction of the later entries, and pickup takes 8 remainder steps plus compaction.
// Throughput: one word at a time; set by the table walked one entry per cycle on its read port.
// The result sits in an output register, so the next word is taken while it waits.
// Reset clears the count and all control; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_card_set_table_top
	import ocst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_word_t out_word
);

	logic              start;
	logic              seq_idle;
	logic              res_valid;
	logic              res_take;
	out_word_t         res;
	mem_req_t          mem_req;
	logic [CODE_W-1:0] rdata;
	logic              out_valid_q;
	out_word_t         out_word_q;

	assign in_ready = seq_idle;
	assign start    = in_valid && in_ready;
	assign res_take = !out_valid_q || out_ready;

	ocst_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.in_word   (in_word),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	ocst_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.count <= COUNT_W'(CAPACITY)))
		else $error("count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.ok) |->
		(out_word.where == '0 && out_word.out_suit == '0 && out_word.out_number == '0))
		else $error("failed word carries nonzero fields");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word taken while busy");

	a_where_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.ok) |-> (COUNT_W'(out_word.where) <= out_word.count))
		else $error("position beyond count");
`endif

endmodule

`default_nettype wire
